// ----- sv/ehpd_pkg.sv -----
`timescale 1ns / 1ps
package ehpd_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] ENC_ALIGNED   = 8'h50;
  localparam logic [7:0] ENC_INDIRECT  = 8'h80;
  localparam logic [3:0] LO_ULEB128    = 4'h1;
  localparam logic [3:0] LO_SLEB128    = 4'h9;
  localparam logic [3:0] LO_UDATA2     = 4'h2;
  localparam logic [3:0] LO_UDATA8     = 4'h4;
  localparam logic [3:0] LO_SDATA8     = 4'hc;
  localparam logic [2:0] SEL_PCREL     = 3'h1;
  localparam logic [2:0] SEL_TEXTREL   = 3'h2;
  localparam logic [2:0] SEL_DATAREL   = 3'h3;
  localparam logic [2:0] SEL_FUNCREL   = 3'h4;
  localparam logic [2:0] SEL_ALIGNED   = 3'h5;

  localparam logic [1:0] CFG_TEXT_REL_BASE = 2'd0;
  localparam logic [1:0] CFG_DATA_REL_BASE = 2'd1;
  localparam logic [1:0] CFG_REGION_START  = 2'd2;

  typedef struct packed {
    logic        first;
    logic [7:0]  encoding;
    logic [7:0]  data_byte;
    logic [31:0] byte_address;
  } in_item_t;

  typedef struct packed {
    logic [63:0] decoded_value;
    logic        indirect_wanted;
    logic        status;
  } out_item_t;

  typedef struct packed {
    logic     err;
    in_item_t beat;
  } q_item_t;

  typedef struct packed {
    logic [31:0] text_rel_base;
    logic [31:0] data_rel_base;
    logic [31:0] region_start;
  } cfg_t;

  function automatic logic enc_valid(input logic [7:0] e);
    logic lo_ok;
    lo_ok = (e[3:0] <= 4'h4) || ((e[3:0] >= 4'h9) && (e[3:0] <= 4'hc));
    return lo_ok && (e[6:4] <= SEL_ALIGNED);
  endfunction

endpackage

// ----- sv/ehpd_front.sv -----
`timescale 1ns / 1ps
module ehpd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ehpd_pkg::in_item_t in_data,
  output logic              deq_valid,
  input  logic              deq_ready,
  output ehpd_pkg::q_item_t deq_item
);
  import ehpd_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  q_item_t        q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;
  q_item_t        cls;

  assign in_ready  = (count != CW'(QUEUE_DEPTH));
  assign deq_valid = (count != '0);
  assign deq_item  = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = deq_valid && deq_ready;

  // invalid encodings flagged here, back end just reports them
  always_comb begin
    cls.beat = in_data;
    cls.err  = in_data.first && !enc_valid(in_data.encoding);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/ehpd_back.sv -----
`timescale 1ns / 1ps
module ehpd_back (
  input  logic               clk,
  input  logic               rst,
  input  ehpd_pkg::cfg_t     cfg,
  input  logic               deq_valid,
  output logic               deq_ready,
  input  ehpd_pkg::q_item_t  deq_item,
  output logic               out_valid,
  input  logic               out_ready,
  output ehpd_pkg::out_item_t out_data
);
  import ehpd_pkg::*;

  localparam logic [63:0] ONES = '1;

  logic        busy;
  logic [7:0]  held_encoding;
  logic [63:0] accumulator;
  logic [6:0]  byte_shift;
  logic [31:0] start_address;

  logic        c_busy;
  logic [7:0]  c_enc;
  logic [63:0] c_acc;
  logic [6:0]  c_shift;
  logic [31:0] c_start;
  logic        busy_next;
  logic [63:0] accumulator_next;
  logic [6:0]  byte_shift_next;
  logic        done;
  logic        res_err;
  logic [6:0]  bits;
  logic [31:0] base;
  logic [7:0]  b;
  logic [31:0] addr;
  logic        pop;
  out_item_t   res;

  assign deq_ready = !out_valid || out_ready;
  assign pop       = deq_valid && deq_ready;
  assign b         = deq_item.beat.data_byte;
  assign addr      = deq_item.beat.byte_address;

  always_comb begin
    c_busy  = busy;
    c_enc   = held_encoding;
    c_acc   = accumulator;
    c_shift = byte_shift;
    c_start = start_address;
    if (deq_item.beat.first) begin
      c_busy  = !deq_item.err;
      c_enc   = deq_item.beat.encoding;
      c_acc   = '0;
      c_shift = '0;
      c_start = addr;
    end
    accumulator_next = c_acc;
    byte_shift_next  = c_shift;
    done    = 1'b0;
    res_err = 1'b0;
    bits    = 7'd32;
    if (deq_item.beat.first && deq_item.err) begin
      done    = 1'b1;
      res_err = 1'b1;
    end else if (c_busy) begin
      if (c_enc == ENC_ALIGNED) begin
        // padding skipped until the word boundary
        if (!((c_shift == '0) && (addr[1:0] != 2'b00))) begin
          accumulator_next = c_acc | ({56'b0, b} << c_shift[5:0]);
          byte_shift_next  = c_shift + 7'd8;
          done = (byte_shift_next >= 7'd32);
        end
      end else if ((c_enc[3:0] == LO_ULEB128) || (c_enc[3:0] == LO_SLEB128)) begin
        if (c_shift < 7'd64) begin
          accumulator_next = c_acc | ({57'b0, b[6:0]} << c_shift[5:0]);
          byte_shift_next  = c_shift + 7'd7;
        end
        if (!b[7]) begin
          if ((c_enc[3:0] == LO_SLEB128) && (byte_shift_next < 7'd64) && b[6]) begin
            accumulator_next = accumulator_next | (ONES << byte_shift_next[5:0]);
          end
          done = 1'b1;
        end
      end else begin
        if (c_enc[2:0] == LO_UDATA2[2:0]) begin
          bits = 7'd16;
        end else if (c_enc[2:0] == LO_UDATA8[2:0]) begin
          bits = 7'd64;
        end
        accumulator_next = c_acc | ({56'b0, b} << c_shift[5:0]);
        byte_shift_next  = c_shift + 7'd8;
        if (byte_shift_next >= bits) begin
          if (c_enc[3] && b[7] && (bits != 7'd64)) begin
            accumulator_next = accumulator_next | (ONES << bits[5:0]);
          end
          done = 1'b1;
        end
      end
    end
    busy_next = c_busy && !done;

    case (c_enc[6:4])
      SEL_PCREL:   base = c_start;
      SEL_TEXTREL: base = cfg.text_rel_base;
      SEL_DATAREL: base = cfg.data_rel_base;
      SEL_FUNCREL: base = cfg.region_start;
      default:     base = '0;
    endcase

    if (res_err) begin
      res.decoded_value   = '0;
      res.indirect_wanted = 1'b0;
      res.status          = 1'b1;
    end else if ((c_enc == ENC_ALIGNED) || (accumulator_next == '0)) begin
      res.decoded_value   = accumulator_next;
      res.indirect_wanted = 1'b0;
      res.status          = 1'b0;
    end else begin
      res.decoded_value   = accumulator_next + {32'b0, base};
      res.indirect_wanted = (c_enc & ENC_INDIRECT) != 8'h00;
      res.status          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      held_encoding <= c_enc;
      accumulator   <= accumulator_next;
      byte_shift    <= byte_shift_next;
      start_address <= c_start;
    end
    if (pop && done) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= busy_next;
      end
      if (pop && done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/eh_pointer_encoding_decoder.sv -----
`timescale 1ns / 1ps
// out_valid is registered: it rises after the back end takes the completing beat from the queue
// throughput: one byte per cycle while out_ready does not stall the output; the queue holds two entries
// every byte of a value is its own beat, padding bytes before an aligned word included
// reset: synchronous, clears queue, busy flag and output valid; base registers reset to 0
module eh_pointer_encoding_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ehpd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ehpd_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import ehpd_pkg::*;

  cfg_t    cfg;
  logic    deq_valid;
  logic    deq_ready;
  q_item_t deq_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXT_REL_BASE: cfg.text_rel_base <= cfg_data;
        CFG_DATA_REL_BASE: cfg.data_rel_base <= cfg_data;
        CFG_REGION_START:  cfg.region_start  <= cfg_data;
        default: ;
      endcase
    end
  end

  ehpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_item  (deq_item)
  );

  ehpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_item  (deq_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |->
      (out_data.decoded_value == '0) && !out_data.indirect_wanted)
    else $error("error result carries a value");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("waiting result beat changed");

  a_push_seen: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $past(in_valid && in_ready) |-> deq_valid)
    else $error("accepted beat missing from queue");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import ehpd_pkg::*;

  localparam logic [3:0] LO_ABSPTR    = 4'h0;
  localparam logic [3:0] LO_UDATA4    = 4'h3;
  localparam logic [3:0] LO_SDATA2    = 4'ha;
  localparam logic [3:0] LO_SDATA4    = 4'hb;
  localparam logic [3:0] LO_RESERVED  = 4'hf;
  localparam logic [2:0] SEL_ABSPTR   = 3'h0;
  localparam logic [2:0] SEL_RESERVED = 3'h6;
  localparam logic [7:0] ENC_OMIT     = 8'hff;
  localparam logic [3:0] LO_CODES [9] = '{LO_ABSPTR, LO_ULEB128, LO_UDATA2, LO_UDATA4,
                                          LO_UDATA8, LO_SLEB128, LO_SDATA2, LO_SDATA4,
                                          LO_SDATA8};
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 200;

  typedef struct packed {
    logic      typed;
    logic      yields;
    out_item_t val;
  } pin_t;

  typedef struct packed {
    pin_t     pin;
    in_item_t item;
  } dir_row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  logic stall_hold = 1'b0;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   errors    = 0;
  int   quiet     = 0;
  int   beats_sent = 0;

  // decoder copy
  logic        dec_busy;
  logic [7:0]  dec_enc;
  logic [63:0] dec_acc;
  logic [7:0]  dec_shift;
  logic [31:0] dec_start;
  logic        dec_sign;
  logic [31:0] base_text;
  logic [31:0] base_data;
  logic [31:0] base_func;

  out_item_t decoded_q[$];
  pin_t      offered_q[$];

  eh_pointer_encoding_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] enc(input logic ind, input logic [2:0] sel,
                                     input logic [3:0] lo);
    return {ind, sel, lo};
  endfunction

  function automatic in_item_t beat(input logic first, input logic [7:0] e,
                                    input logic [7:0] b, input logic [31:0] a);
    in_item_t it;
    it.first        = first;
    it.encoding     = e;
    it.data_byte    = b;
    it.byte_address = a;
    return it;
  endfunction

  function automatic pin_t known(input logic yields, input logic [63:0] v,
                                 input logic ind, input logic st);
    pin_t p;
    p.typed               = 1'b1;
    p.yields              = yields;
    p.val.decoded_value   = v;
    p.val.indirect_wanted = ind;
    p.val.status          = st;
    return p;
  endfunction

  function automatic logic encoding_supported(input logic [7:0] e);
    logic lo_ok;
    lo_ok = (e[3:0] <= LO_UDATA8) || ((e[3:0] >= LO_SLEB128) && (e[3:0] <= LO_SDATA8));
    return lo_ok && (e[6:4] <= SEL_ALIGNED);
  endfunction

  // adds the base (unless aligned or zero) and closes the value in progress
  function automatic out_item_t close_value();
    out_item_t   r;
    logic [63:0] v;
    logic        ind;
    v   = dec_acc;
    ind = 1'b0;
    if (dec_enc != ENC_ALIGNED && v != 64'd0) begin
      case (dec_enc[6:4])
        SEL_PCREL:   v = v + {32'd0, dec_start};
        SEL_TEXTREL: v = v + {32'd0, base_text};
        SEL_DATAREL: v = v + {32'd0, base_data};
        SEL_FUNCREL: v = v + {32'd0, base_func};
        default: ;
      endcase
      ind = dec_enc[7];
    end
    dec_busy          = 1'b0;
    r.decoded_value   = v;
    r.indirect_wanted = ind;
    r.status          = 1'b0;
    return r;
  endfunction

  task automatic decode_byte(input in_item_t it, output logic emits, output out_item_t res);
    logic [3:0] lo;
    int         width;
    emits = 1'b0;
    res   = '0;
    if (it.first) begin
      dec_enc   = it.encoding;
      dec_acc   = 64'd0;
      dec_shift = 8'd0;
      dec_start = it.byte_address;
      dec_sign  = 1'b0;
      dec_busy  = 1'b0;
      if (!encoding_supported(it.encoding)) begin
        emits      = 1'b1;
        res.status = 1'b1;
        return;
      end
      dec_busy = 1'b1;
    end
    if (!dec_busy) return;
    lo = dec_enc[3:0];
    if (dec_enc == ENC_ALIGNED) begin
      // padding before the word
      if (dec_shift == 8'd0 && it.byte_address[1:0] != 2'd0) return;
      dec_acc   = dec_acc | (64'(it.data_byte) << dec_shift);
      dec_shift = dec_shift + 8'd8;
      dec_sign  = it.data_byte[7];
      if (dec_shift >= 8'd32) begin
        emits = 1'b1;
        res   = close_value();
      end
    end else if (lo == LO_ULEB128 || lo == LO_SLEB128) begin
      if (dec_shift < 8'd64) begin
        dec_acc   = dec_acc | (64'(it.data_byte[6:0]) << dec_shift);
        dec_shift = dec_shift + 8'd7;
      end
      dec_sign = it.data_byte[6];
      if (!it.data_byte[7]) begin
        if (lo == LO_SLEB128 && dec_shift < 8'd64 && dec_sign)
          dec_acc = dec_acc | (~64'd0 << dec_shift);
        emits = 1'b1;
        res   = close_value();
      end
    end else begin
      case (lo[2:0])
        LO_UDATA2[2:0]: width = 16;
        LO_UDATA8[2:0]: width = 64;
        default:        width = 32;
      endcase
      dec_acc   = dec_acc | (64'(it.data_byte) << dec_shift[5:0]);
      dec_shift = dec_shift + 8'd8;
      dec_sign  = it.data_byte[7];
      if (int'(dec_shift) >= width) begin
        if (lo[3] && dec_sign && width < 64) dec_acc = dec_acc | (~64'd0 << width);
        emits = 1'b1;
        res   = close_value();
      end
    end
  endtask

  task automatic offer(input in_item_t it, input pin_t pin);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    offered_q.push_back(pin);
    in_valid <= 1'b1;
    in_data  <= it;
    beats_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      CFG_TEXT_REL_BASE: base_text = v;
      CFG_DATA_REL_BASE: base_data = v;
      CFG_REGION_START:  base_func = v;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_bases(input logic [31:0] t, input logic [31:0] d,
                             input logic [31:0] r);
    write_reg(CFG_TEXT_REL_BASE, t);
    write_reg(CFG_DATA_REL_BASE, d);
    write_reg(CFG_REGION_START, r);
    @(posedge clk);
  endtask

  // an omit byte closes whatever is open, then wait for the block to empty
  task automatic drain();
    offer(beat(1'b1, ENC_OMIT, 8'h00, 32'h0), known(1'b1, 64'd0, 1'b0, 1'b1));
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one encoded value, mostly well formed
  task automatic play_value();
    logic [7:0]  e;
    logic [7:0]  b;
    logic [31:0] a;
    int          r;
    int          n;
    int          keep;
    logic        zero;
    logic        leb;
    r = $urandom_range(99);
    a = $urandom;
    if (r < 5) begin
      offer(beat(1'($urandom), 8'($urandom), 8'($urandom), a), '0);
      return;
    end
    if (r < 10) begin
      do e = 8'($urandom); while (encoding_supported(e));
      offer(beat(1'b1, e, 8'($urandom), a), '0);
      return;
    end
    if (r < 22) e = ENC_ALIGNED;
    else e = enc(1'($urandom), 3'($urandom_range(5)), LO_CODES[$urandom_range(8)]);
    leb = (e[3:0] == LO_ULEB128 || e[3:0] == LO_SLEB128) && e != ENC_ALIGNED;
    if (e == ENC_ALIGNED) n = ((4 - int'(a[1:0])) & 3) + 4;
    else if (leb) n = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
    else if (e[2:0] == LO_UDATA2[2:0]) n = 2;
    else if (e[2:0] == LO_UDATA8[2:0]) n = 8;
    else n = 4;
    zero = ($urandom_range(9) == 0);
    keep = ($urandom_range(9) == 0) ? $urandom_range(1, n) : n;
    for (int i = 0; i < keep; i++) begin
      b = zero ? 8'h00 : 8'($urandom);
      if (leb) b[7] = (i != n - 1);
      offer(beat(i == 0, e, b, a + 32'(i)), '0);
    end
    if ($urandom_range(9) == 0) offer(beat(1'b0, 8'($urandom), 8'($urandom), $urandom), '0);
  endtask

  task automatic run_phase(input int idle, input int stall, input bit squeeze);
    idle_pct  = idle;
    stall_pct = stall;
    beats_sent = 0;
    if (squeeze) begin
      fork
        begin
          stall_hold <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          stall_hold <= 1'b0;
        end
      join_none
    end
    while (beats_sent < PHASE_ITEMS) play_value();
    drain();
  endtask

  always @(posedge clk) begin
    out_ready <= !stall_hold && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : check
    out_item_t want;
    out_item_t got;
    pin_t      pin;
    logic      emits;
    if (rst) begin
      quiet <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t result with none expected: %h", $time, out_data);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          if (out_data.decoded_value !== want.decoded_value) begin
            $display("%0t decoded_value expected %h got %h", $time,
                     want.decoded_value, out_data.decoded_value);
            errors++;
          end
          if (out_data.indirect_wanted !== want.indirect_wanted) begin
            $display("%0t indirect_wanted expected %b got %b", $time,
                     want.indirect_wanted, out_data.indirect_wanted);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $display("%0t status expected %b got %b", $time, want.status, out_data.status);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pin = offered_q.pop_front();
        decode_byte(in_data, emits, got);
        if (pin.typed) begin
          if (pin.yields) decoded_q.push_back(pin.val);
        end else if (emits) begin
          decoded_q.push_back(got);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("eh_pointer_encoding_decoder test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    dir_row_t dir_tab[$];
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_TEXT_REL_BASE;
    cfg_data  <= 32'h0;
    dec_busy  = 1'b0;
    dec_enc   = 8'h00;
    dec_acc   = 64'd0;
    dec_shift = 8'd0;
    dec_start = 32'h0;
    dec_sign  = 1'b0;
    base_text = 32'h0;
    base_data = 32'h0;
    base_func = 32'h0;

    // errors, then a stray beat
    dir_tab.push_back('{known(1'b1, 64'd0, 1'b0, 1'b1), beat(1'b1, ENC_OMIT, 8'h00, 32'h0)});
    dir_tab.push_back('{known(1'b1, 64'd0, 1'b0, 1'b1),
                        beat(1'b1, enc(1'b0, SEL_ABSPTR, LO_RESERVED), 8'hff, 32'hffffffff)});
    dir_tab.push_back('{known(1'b1, 64'd0, 1'b0, 1'b1),
                        beat(1'b1, enc(1'b0, SEL_RESERVED, LO_ABSPTR), 8'h12, 32'h10)});
    dir_tab.push_back('{known(1'b0, 64'd0, 1'b0, 1'b0), beat(1'b0, 8'h00, 8'hab, 32'h20)});
    // two-byte forms at the extremes
    dir_tab.push_back('{known(1'b0, 64'd0, 1'b0, 1'b0),
                        beat(1'b1, enc(1'b0, SEL_ABSPTR, LO_UDATA2), 8'hff, 32'h100)});
    dir_tab.push_back('{known(1'b1, 64'h000000000000ffff, 1'b0, 1'b0),
                        beat(1'b0, 8'h00, 8'hff, 32'h101)});
    dir_tab.push_back('{known(1'b0, 64'd0, 1'b0, 1'b0),
                        beat(1'b1, enc(1'b0, SEL_ABSPTR, LO_SDATA2), 8'h00, 32'h200)});
    dir_tab.push_back('{known(1'b1, 64'hffffffffffff8000, 1'b0, 1'b0),
                        beat(1'b0, 8'h00, 8'h80, 32'h201)});
    // single-byte leb
    dir_tab.push_back('{known(1'b1, 64'h000000000000007f, 1'b0, 1'b0),
                        beat(1'b1, enc(1'b0, SEL_ABSPTR, LO_ULEB128), 8'h7f, 32'h300)});
    dir_tab.push_back('{known(1'b1, 64'hffffffffffffffc0, 1'b0, 1'b0),
                        beat(1'b1, enc(1'b0, SEL_ABSPTR, LO_SLEB128), 8'h40, 32'h301)});
    // pc-relative near the top of the address space
    dir_tab.push_back('{pin_t'('0),
                        beat(1'b1, enc(1'b0, SEL_PCREL, LO_UDATA2), 8'h01, 32'hfffffff0)});
    dir_tab.push_back('{pin_t'('0), beat(1'b0, 8'h00, 8'h00, 32'hfffffff1)});
    // zero value: no base, no indirect
    dir_tab.push_back('{known(1'b0, 64'd0, 1'b0, 1'b0),
                        beat(1'b1, enc(1'b1, SEL_PCREL, LO_UDATA2), 8'h00, 32'h400)});
    dir_tab.push_back('{known(1'b1, 64'd0, 1'b0, 1'b0), beat(1'b0, 8'h00, 8'h00, 32'h401)});
    // aligned word after one padding byte
    dir_tab.push_back('{pin_t'('0), beat(1'b1, ENC_ALIGNED, 8'hee, 32'h203)});
    dir_tab.push_back('{pin_t'('0), beat(1'b0, 8'h00, 8'h11, 32'h204)});
    dir_tab.push_back('{pin_t'('0), beat(1'b0, 8'h00, 8'h22, 32'h205)});
    dir_tab.push_back('{pin_t'('0), beat(1'b0, 8'h00, 8'h33, 32'h206)});
    dir_tab.push_back('{pin_t'('0), beat(1'b0, 8'h00, 8'h44, 32'h207)});
    // a new first beat abandons the open value
    dir_tab.push_back('{known(1'b0, 64'd0, 1'b0, 1'b0),
                        beat(1'b1, enc(1'b0, SEL_ABSPTR, LO_UDATA4), 8'h55, 32'h500)});
    dir_tab.push_back('{known(1'b1, 64'h0000000000000005, 1'b0, 1'b0),
                        beat(1'b1, enc(1'b0, SEL_ABSPTR, LO_ULEB128), 8'h05, 32'h501)});
    // indirect, text-relative with zero base
    dir_tab.push_back('{known(1'b1, 64'h0000000000000001, 1'b1, 1'b0),
                        beat(1'b1, enc(1'b1, SEL_TEXTREL, LO_ULEB128), 8'h01, 32'h600)});

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) offer(dir_tab[i].item, dir_tab[i].pin);
    drain();

    write_bases(32'hffffffff, 32'hffffffff, 32'hffffffff);
    run_phase(0, 0, 1'b0);
    write_bases($urandom, $urandom, $urandom);
    run_phase(61, 0, 1'b0);
    write_bases($urandom, $urandom, $urandom);
    run_phase(0, 61, 1'b0);
    write_bases(32'h00000001, 32'h80000000, 32'h7fffffff);
    run_phase(11, 11, 1'b0);
    write_bases($urandom, $urandom, $urandom);
    run_phase(0, 0, 1'b1);

    if (errors == 0) begin
      $display("eh_pointer_encoding_decoder test passed");
    end else begin
      $display("eh_pointer_encoding_decoder test failed");
    end
    $finish;
  end

endmodule

// ----- eh_pointer_encoding_decoder.f -----
sv/ehpd_pkg.sv
sv/ehpd_front.sv
sv/ehpd_back.sv
sv/eh_pointer_encoding_decoder.sv
dv/testbench.sv
